>>> design/fspc_pkg.sv
// ----------------------------------------------------------------------------
// Frame stack pixel combine package
// Shared widths, mode codes, payload structs and a small helper function.
// ----------------------------------------------------------------------------
`default_nettype none

package fspc_pkg;

  localparam int COLOR_BITS  = 16;
  localparam int FIELD_W     = 16;
  localparam int VSUM_W      = 38;
  localparam int WSUM_W      = 23;
  localparam int PROD_W      = 2 * FIELD_W;
  localparam int CNT_W       = $clog2(VSUM_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FIELD_W-1:0] FULL_SCALE = FIELD_W'((1 << COLOR_BITS) - 1);
  localparam logic [VSUM_W-1:0]  VSUM_MAX   = {VSUM_W{1'b1}};
  localparam logic [WSUM_W-1:0]  WSUM_MAX   = {WSUM_W{1'b1}};

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_PLAIN = 2'd0;
  localparam mode_t MODE_ALPHA = 2'd1;
  localparam mode_t MODE_DARK  = 2'd2;
  // Unassigned selector value, decodes as plain average
  localparam mode_t MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [FIELD_W-1:0] sample_value;
    logic               sample_valid;
    logic [FIELD_W-1:0] weight_value;
    logic               weight_present;
    logic               last_sample;
  } sample_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pixel_value;
    logic [FIELD_W-1:0] pixel_alpha;
  } pixel_t;

  // One finished pixel handed from the accumulator to the divider
  typedef struct packed {
    mode_t              mode;
    logic [VSUM_W-1:0]  value_sum;
    logic [WSUM_W-1:0]  weight_sum;
    logic [FIELD_W-1:0] running_min;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

  function automatic logic [FIELD_W-1:0] clamp_full(input logic [FIELD_W-1:0] x);
    return (x > FULL_SCALE) ? FULL_SCALE : x;
  endfunction

endpackage

`default_nettype wire

>>> design/fspc_front.sv
// ----------------------------------------------------------------------------
// Frame stack accumulator front end
// Registers each sample with its weighted product, then folds it into the
// running sums (not dark mode) and minimum; last sample pushes a queue job.
// ----------------------------------------------------------------------------
`default_nettype none

module fspc_front
  import fspc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire mode_t   mode,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire sample_t in_data,
  output logic         push,
  output job_t         push_data,
  input  wire logic    queue_full
);

  logic [FIELD_W-1:0] v_in;
  logic [FIELD_W-1:0] w_in;
  logic [FIELD_W-1:0] wt_in;
  logic [PROD_W-1:0]  prod_in;
  logic               accept;

  // Stage A: registered sample
  logic               a_valid;
  logic               a_last;
  logic               a_smp_valid;
  mode_t              a_mode;
  logic [FIELD_W-1:0] a_v;
  logic [PROD_W-1:0]  a_prod;
  logic [FIELD_W-1:0] a_winc;
  logic               a_advance;

  // Accumulators
  logic [VSUM_W-1:0]  value_sum;
  logic [WSUM_W-1:0]  weight_sum;
  logic [FIELD_W-1:0] running_min;

  logic               add_en;
  logic [VSUM_W:0]    vsum_raw;
  logic [WSUM_W:0]    wsum_raw;
  logic [VSUM_W-1:0]  vsum_new;
  logic [WSUM_W-1:0]  wsum_new;
  logic [FIELD_W-1:0] min_new;

  always_comb begin
    v_in    = clamp_full(in_data.sample_value);
    w_in    = clamp_full(in_data.weight_value);
    wt_in   = in_data.weight_present ? w_in : FULL_SCALE;
    prod_in = {{FIELD_W{1'b0}}, v_in} * {{FIELD_W{1'b0}}, wt_in};
  end

  // Stall the last sample only while the queue has no room
  assign a_advance = a_valid && !(a_last && queue_full);
  assign in_ready  = !a_valid || a_advance;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_last      <= in_data.last_sample;
      a_smp_valid <= in_data.sample_valid;
      a_mode      <= mode;
      a_v         <= v_in;
      a_prod      <= (mode == MODE_ALPHA) ? prod_in : {{FIELD_W{1'b0}}, v_in};
      a_winc      <= (mode == MODE_ALPHA) ? wt_in : FIELD_W'(1);
    end
  end

  always_comb begin
    add_en   = a_smp_valid && (a_mode != MODE_DARK);
    vsum_raw = {1'b0, value_sum}
             + (add_en ? (VSUM_W + 1)'(a_prod) : '0);
    wsum_raw = {1'b0, weight_sum}
             + (add_en ? (WSUM_W + 1)'(a_winc) : '0);
    vsum_new = vsum_raw[VSUM_W] ? VSUM_MAX : vsum_raw[VSUM_W-1:0];
    wsum_new = wsum_raw[WSUM_W] ? WSUM_MAX : wsum_raw[WSUM_W-1:0];
    min_new  = (a_smp_valid && (a_v < running_min)) ? a_v : running_min;

    push                  = a_advance && a_last;
    push_data.mode        = a_mode;
    push_data.value_sum   = vsum_new;
    push_data.weight_sum  = wsum_new;
    push_data.running_min = min_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_sum   <= '0;
      weight_sum  <= '0;
      running_min <= FULL_SCALE;
    end else if (a_advance) begin
      if (a_last) begin
        value_sum   <= '0;
        weight_sum  <= '0;
        running_min <= FULL_SCALE;
      end else begin
        value_sum   <= vsum_new;
        weight_sum  <= wsum_new;
        running_min <= min_new;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/fspc_queue.sv
// ----------------------------------------------------------------------------
// Frame stack job queue
// Short first-in first-out buffer of finished pixel jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module fspc_queue
  import fspc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output logic      pop_valid,
  output job_t      pop_data
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/fspc_back.sv
// ----------------------------------------------------------------------------
// Frame stack result back end
// Takes queued pixel jobs, passes a dark job's minimum or divides value sum
// by weight sum one quotient bit per cycle; result held in output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fspc_back
  import fspc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output pixel_t    out_data
);

  back_state_t        state, state_next;
  logic [VSUM_W-1:0]  dvd, dvd_next;
  logic [WSUM_W-1:0]  rem, rem_next;
  logic [WSUM_W-1:0]  divisor, divisor_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  pixel_t             res, res_next;
  logic               out_load;

  logic [WSUM_W:0]    trial;
  logic [WSUM_W:0]    diff;
  logic               qbit;
  logic [VSUM_W-1:0]  quo;

  always_comb begin
    trial = {rem, dvd[VSUM_W-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = (trial >= {1'b0, divisor});
    quo   = {dvd[VSUM_W-2:0], qbit};
  end

  always_comb begin
    state_next   = state;
    dvd_next     = dvd;
    rem_next     = rem;
    divisor_next = divisor;
    cnt_next     = cnt;
    res_next     = res;
    pop          = 1'b0;
    out_load     = 1'b0;

    unique case (state)
      B_IDLE: begin
        if (job_valid) begin
          pop = 1'b1;
          if (job.mode == MODE_DARK) begin
            res_next.pixel_value = job.running_min;
            res_next.pixel_alpha = FULL_SCALE;
            state_next           = B_DONE;
          end else if (job.weight_sum == '0) begin
            res_next.pixel_value = '0;
            res_next.pixel_alpha = '0;
            state_next           = B_DONE;
          end else begin
            dvd_next     = job.value_sum;
            rem_next     = '0;
            divisor_next = job.weight_sum;
            cnt_next     = CNT_W'(VSUM_W - 1);
            state_next   = B_DIV;
          end
        end
      end
      B_DIV: begin
        dvd_next = quo;
        rem_next = qbit ? diff[WSUM_W-1:0] : trial[WSUM_W-1:0];
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          // Clamp the quotient to full scale
          if ((|quo[VSUM_W-1:COLOR_BITS]) || (FIELD_W'(quo[COLOR_BITS-1:0]) > FULL_SCALE)) begin
            res_next.pixel_value = FULL_SCALE;
          end else begin
            res_next.pixel_value = FIELD_W'(quo[COLOR_BITS-1:0]);
          end
          res_next.pixel_alpha = FULL_SCALE;
          state_next           = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd     <= dvd_next;
    rem     <= rem_next;
    divisor <= divisor_next;
    cnt     <= cnt_next;
    res     <= res_next;
    if (out_load) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

>>> design/frame_stack_pixel_combine.sv
// ----------------------------------------------------------------------------
// Frame stack pixel combine
// Averages, alpha-weights or takes the minimum of a pixel's frame samples.
// ----------------------------------------------------------------------------
// Channel   Signals                          Handshake
// input     in_valid, in_ready, in_data      valid/ready, sample_t
// output    out_valid, out_ready, out_data   valid/ready, pixel_t
// config    cfg_write, cfg_data              write enable, combine_mode
//
// Samples enter the accumulator one per cycle while it is not stalled.
// The last sample of a pixel queues a job. The back end pops an averaging job,
// runs the shift-subtract divider and loads the output register; a minimum or
// empty job goes straight to the output load. No new job is taken meanwhile.
// The 2-entry job queue lets sampling continue while the divider works;
// the last sample stalls only when the queue is full.
// Synchronous reset zeroes sums, queue, mode, out_valid; min to full scale.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_stack_pixel_combine
  import fspc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    cfg_write,
  input  wire mode_t   cfg_data,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire sample_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output pixel_t       out_data
);

  mode_t combine_mode;
  logic  push;
  job_t  push_data;
  logic  queue_full;
  logic  pop;
  logic  job_valid;
  job_t  job;

  always_ff @(posedge clk) begin
    if (rst) begin
      combine_mode <= MODE_PLAIN;
    end else if (cfg_write) begin
      combine_mode <= cfg_data;
    end
  end

  fspc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (combine_mode),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  fspc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (job_valid),
    .pop_data  (job)
  );

  fspc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
